// ----- rtl/core/mm3_pkg.sv -----
package mm3_pkg;

	// mixing and finalizer constants
	localparam logic [63:0] MUL_A   = 64'h87c3_7b91_1142_53d5;
	localparam logic [63:0] MUL_B   = 64'h4cf5_ad43_2745_937f;
	localparam logic [63:0] ADD_ONE = 64'h0000_0000_52dc_e729;
	localparam logic [63:0] ADD_TWO = 64'h0000_0000_3849_5ab5;
	localparam logic [63:0] FIN_A   = 64'hff51_afd7_ed55_8ccd;
	localparam logic [63:0] FIN_B   = 64'hc4ce_b9fe_1a85_ec53;

	// block geometry
	localparam int unsigned BLOCK_BYTES = 16;
	localparam int unsigned LANE_BYTES  = 8;

	// command queue between front and back
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	// one classified block
	typedef struct packed {
		logic [63:0] lo;
		logic [63:0] hi;
		logic [4:0]  nbytes;
		logic        last;
		logic        full_mix;
		logic        mix_one;
		logic        mix_two;
	} mm3_cmd_t;

	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} mm3_mul_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] prod;
	} mm3_mul_rsp_t;

	// byte mask for the low nb bytes of one lane, all ones from eight up
	function automatic logic [63:0] lane_mask(input logic [3:0] nb);
		logic [63:0] m;
		for (int i = 0; i < LANE_BYTES; i++) begin
			m[8*i +: 8] = (nb > 4'(i)) ? 8'hff : 8'h00;
		end
		return m;
	endfunction

	function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned n);
		return (v << n) | (v >> (64 - n));
	endfunction

	function automatic logic [63:0] xshift33(input logic [63:0] v);
		return v ^ (v >> 33);
	endfunction

endpackage

// ----- rtl/core/mm3_front.sv -----
module mm3_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [63:0]         block_low,
	input  logic [63:0]         block_high,
	input  logic [4:0]          byte_count,
	input  logic                last,
	output logic                cmd_avail,
	output mm3_pkg::mm3_cmd_t   cmd_out,
	input  logic                cmd_pop
);

	mm3_pkg::mm3_cmd_t                 q_mem [mm3_pkg::QDEPTH];
	logic [mm3_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [mm3_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [mm3_pkg::QCNT_W-1:0]        cnt_q;
	mm3_pkg::mm3_cmd_t                 cmd_new;
	logic [4:0]                        n_sat;
	logic [3:0]                        hi_n;
	logic                              push_ok;
	logic                              pop_ok;

	assign full      = (cnt_q == mm3_pkg::QCNT_W'(mm3_pkg::QDEPTH));
	assign cmd_avail = (cnt_q != '0);
	assign push_ok   = push && !full;
	assign pop_ok    = cmd_pop && cmd_avail;
	assign cmd_out   = q_mem[rd_ptr_q];

	// classify: saturate count, pick full mix or tail, mask unused bytes
	always_comb begin
		n_sat = (byte_count > 5'(mm3_pkg::BLOCK_BYTES)) ? 5'(mm3_pkg::BLOCK_BYTES) : byte_count;
		hi_n  = (n_sat > 5'(mm3_pkg::LANE_BYTES)) ? 4'(n_sat - 5'(mm3_pkg::LANE_BYTES)) : 4'd0;
		cmd_new.last     = last;
		cmd_new.full_mix = !last || (n_sat == 5'(mm3_pkg::BLOCK_BYTES));
		cmd_new.nbytes   = cmd_new.full_mix ? 5'(mm3_pkg::BLOCK_BYTES) : n_sat;
		cmd_new.mix_one  = !cmd_new.full_mix && (n_sat != 5'd0);
		cmd_new.mix_two  = !cmd_new.full_mix && (n_sat > 5'(mm3_pkg::LANE_BYTES));
		cmd_new.lo = cmd_new.full_mix ? block_low
			: (block_low & mm3_pkg::lane_mask(n_sat[3:0]));
		cmd_new.hi = cmd_new.full_mix ? block_high
			: (block_high & mm3_pkg::lane_mask(hi_n));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push_ok && !pop_ok) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push_ok && pop_ok) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			q_mem[wr_ptr_q] <= cmd_new;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= mm3_pkg::QCNT_W'(mm3_pkg::QDEPTH))
		else $error("command queue count past depth");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		push_ok |=> cmd_avail)
		else $error("accepted item not visible in command queue");

endmodule

// ----- rtl/core/mm3_mul.sv -----
module mm3_mul (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mm3_pkg::mm3_mul_req_t req,
	output mm3_pkg::mm3_mul_rsp_t rsp
);

	logic        busy_q;
	logic [1:0]  cnt_q;
	logic        done_q;
	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] acc_q;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [63:0] part;

	// low 64 bits of a 64x64 product: low x low, then the two cross terms
	always_comb begin
		case (cnt_q)
			2'd0: begin
				op_a = a_q[31:0];
				op_b = b_q[31:0];
			end
			2'd1: begin
				op_a = a_q[31:0];
				op_b = b_q[63:32];
			end
			2'd2: begin
				op_a = a_q[63:32];
				op_b = b_q[31:0];
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
		part = 64'(op_a) * 64'(op_b);
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == 2'd2) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
		end else if (busy_q) begin
			if (cnt_q == 2'd0) begin
				acc_q <= part;
			end else begin
				acc_q[63:32] <= acc_q[63:32] + part[31:0];
			end
		end
	end

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("multiply started while busy");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !req.start && cnt_q == 2'd2) |=> done_q)
		else $error("multiply did not complete");

endmodule

// ----- rtl/core/mm3_back.sv -----
module mm3_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_avail,
	input  mm3_pkg::mm3_cmd_t     cmd_in,
	output logic                  cmd_pop,
	input  logic                  seed_valid,
	input  logic [31:0]           seed,
	output logic                  seed_ready,
	output mm3_pkg::mm3_mul_req_t mul_req,
	input  mm3_pkg::mm3_mul_rsp_t mul_rsp,
	input  logic                  out_pop,
	output logic                  out_valid,
	output logic [63:0]           hash_low,
	output logic [63:0]           hash_high,
	output logic                  too_long
);

	typedef enum logic [16:0] {
		ST_IDLE = 17'd1,
		ST_K1A  = 17'd2,
		ST_K1B  = 17'd4,
		ST_H1A  = 17'd8,
		ST_H1B  = 17'd16,
		ST_K2A  = 17'd32,
		ST_K2B  = 17'd64,
		ST_H2A  = 17'd128,
		ST_H2B  = 17'd256,
		ST_F0   = 17'd512,
		ST_F1   = 17'd1024,
		ST_A1   = 17'd2048,
		ST_A2   = 17'd4096,
		ST_A3   = 17'd8192,
		ST_A4   = 17'd16384,
		ST_G1   = 17'd32768,
		ST_G2   = 17'd65536
	} state_t;

	state_t      state_q, state_d;
	logic [63:0] h1_q, h1_d;
	logic [63:0] h2_q, h2_d;
	logic [31:0] tot_q, tot_d;
	logic        ovf_q, ovf_d;
	logic [31:0] seed_q, seed_d;
	logic        out_valid_q;
	logic        out_free;
	logic        out_ld;
	logic [32:0] tot_sum;
	logic [63:0] tot64;
	logic [63:0] seed64;
	logic [63:0] hi_q;
	logic        full_q;
	logic        mix_two_q;
	logic        last_q;
	logic [63:0] hash_low_q;
	logic [63:0] hash_high_q;
	logic        too_long_q;

	assign out_free   = !out_valid_q || out_pop;
	assign out_valid  = out_valid_q;
	assign hash_low   = hash_low_q;
	assign hash_high  = hash_high_q;
	assign too_long   = too_long_q;
	assign seed_ready = (state_q == ST_IDLE) && !cmd_avail;
	assign tot_sum    = {1'b0, tot_q} + 33'(cmd_in.nbytes);
	assign tot64      = {32'd0, tot_q};
	assign seed64     = {32'd0, seed_q};

	always_comb begin
		state_d     = state_q;
		h1_d        = h1_q;
		h2_d        = h2_q;
		tot_d       = tot_q;
		ovf_d       = ovf_q;
		seed_d      = seed_q;
		cmd_pop     = 1'b0;
		out_ld      = 1'b0;
		mul_req     = '0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_avail) begin
					cmd_pop = 1'b1;
					tot_d   = tot_sum[32] ? '1 : tot_sum[31:0];
					ovf_d   = ovf_q | tot_d[31];
					if (cmd_in.full_mix || cmd_in.mix_one) begin
						mul_req = '{start: 1'b1, a: cmd_in.lo, b: mm3_pkg::MUL_A};
						state_d = ST_K1A;
					end else if (cmd_in.mix_two) begin
						mul_req = '{start: 1'b1, a: cmd_in.hi, b: mm3_pkg::MUL_B};
						state_d = ST_K2A;
					end else begin
						state_d = ST_F0;
					end
				end else if (seed_valid) begin
					seed_d = seed;
					if (tot_q == '0) begin
						h1_d = {32'd0, seed};
						h2_d = {32'd0, seed};
					end
				end
			end
			ST_K1A: begin
				if (mul_rsp.done) begin
					mul_req = '{start: 1'b1, a: mm3_pkg::rotl64(mul_rsp.prod, 31),
						b: mm3_pkg::MUL_B};
					state_d = ST_K1B;
				end
			end
			ST_K1B: begin
				if (mul_rsp.done) begin
					if (full_q) begin
						state_d = ST_H1A;
					end else begin
						h1_d = h1_q ^ mul_rsp.prod;
						if (mix_two_q) begin
							mul_req = '{start: 1'b1, a: hi_q, b: mm3_pkg::MUL_B};
							state_d = ST_K2A;
						end else begin
							state_d = ST_F0;
						end
					end
				end
			end
			ST_H1A: begin
				h1_d    = mm3_pkg::rotl64(h1_q ^ mul_rsp.prod, 27) + h2_q;
				state_d = ST_H1B;
			end
			ST_H1B: begin
				h1_d    = h1_q + (h1_q << 2) + mm3_pkg::ADD_ONE;
				mul_req = '{start: 1'b1, a: hi_q, b: mm3_pkg::MUL_B};
				state_d = ST_K2A;
			end
			ST_K2A: begin
				if (mul_rsp.done) begin
					mul_req = '{start: 1'b1, a: mm3_pkg::rotl64(mul_rsp.prod, 33),
						b: mm3_pkg::MUL_A};
					state_d = ST_K2B;
				end
			end
			ST_K2B: begin
				if (mul_rsp.done) begin
					if (full_q) begin
						state_d = ST_H2A;
					end else begin
						h2_d    = h2_q ^ mul_rsp.prod;
						state_d = ST_F0;
					end
				end
			end
			ST_H2A: begin
				h2_d    = mm3_pkg::rotl64(h2_q ^ mul_rsp.prod, 31) + h1_q;
				state_d = ST_H2B;
			end
			ST_H2B: begin
				h2_d    = h2_q + (h2_q << 2) + mm3_pkg::ADD_TWO;
				state_d = last_q ? ST_F0 : ST_IDLE;
			end
			ST_F0: begin
				h1_d    = (h1_q ^ tot64) + (h2_q ^ tot64);
				h2_d    = h2_q ^ tot64;
				state_d = ST_F1;
			end
			ST_F1: begin
				h2_d    = h2_q + h1_q;
				mul_req = '{start: 1'b1, a: mm3_pkg::xshift33(h1_q), b: mm3_pkg::FIN_A};
				state_d = ST_A1;
			end
			ST_A1: begin
				if (mul_rsp.done) begin
					mul_req = '{start: 1'b1, a: mm3_pkg::xshift33(mul_rsp.prod),
						b: mm3_pkg::FIN_B};
					state_d = ST_A2;
				end
			end
			ST_A2: begin
				if (mul_rsp.done) begin
					h1_d    = mm3_pkg::xshift33(mul_rsp.prod);
					mul_req = '{start: 1'b1, a: mm3_pkg::xshift33(h2_q), b: mm3_pkg::FIN_A};
					state_d = ST_A3;
				end
			end
			ST_A3: begin
				if (mul_rsp.done) begin
					mul_req = '{start: 1'b1, a: mm3_pkg::xshift33(mul_rsp.prod),
						b: mm3_pkg::FIN_B};
					state_d = ST_A4;
				end
			end
			ST_A4: begin
				if (mul_rsp.done) begin
					h2_d    = mm3_pkg::xshift33(mul_rsp.prod);
					state_d = ST_G1;
				end
			end
			ST_G1: begin
				h1_d    = h1_q + h2_q;
				state_d = ST_G2;
			end
			ST_G2: begin
				if (out_free) begin
					out_ld  = 1'b1;
					h1_d    = seed64;
					h2_d    = seed64;
					tot_d   = '0;
					ovf_d   = 1'b0;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			h1_q        <= '0;
			h2_q        <= '0;
			tot_q       <= '0;
			ovf_q       <= 1'b0;
			seed_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			h1_q    <= h1_d;
			h2_q    <= h2_d;
			tot_q   <= tot_d;
			ovf_q   <= ovf_d;
			seed_q  <= seed_d;
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			hi_q      <= cmd_in.hi;
			full_q    <= cmd_in.full_mix;
			mix_two_q <= cmd_in.mix_two;
			last_q    <= cmd_in.last;
		end
		if (out_ld) begin
			hash_low_q  <= h1_q;
			hash_high_q <= h1_q + h2_q;
			too_long_q  <= ovf_q;
		end
	end

	a_start_waits: assert property (@(posedge clk) disable iff (!arst_n)
		mul_req.start |=> (state_q == ST_K1A || state_q == ST_K1B || state_q == ST_K2A ||
			state_q == ST_K2B || state_q == ST_A1 || state_q == ST_A2 ||
			state_q == ST_A3 || state_q == ST_A4))
		else $error("multiply issued without a wait state");

	a_emit_reloads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_G2 && out_free) |=> (out_valid_q && tot_q == '0 && !ovf_q))
		else $error("result emitted without message state reload");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_pop) |=> (out_valid_q && $stable(hash_low_q) &&
			$stable(hash_high_q)))
		else $error("waiting result changed");

endmodule

// ----- rtl/core/murmur3_128bit_stream_hash_core.sv -----
// murmurhash3 x64 128-bit over 16-byte blocks, one shared 32x32 multiplier does all the multiplies
// input items queue up ahead of the back end, which works on one command at a time;
//   each 64-bit product takes three partial products, up to four per block, four more to finalize
// reset: arst_n clears seed to zero, both hash words to zero, length and overflow,
//   the command queue and the result valid flag; no clearing pass
module murmur3_128bit_stream_hash_core (
	input  logic        clk,
	input  logic        arst_n,
	// input side, queue style
	input  logic        push,
	output logic        full,
	input  logic [63:0] block_low,
	input  logic [63:0] block_high,
	input  logic [4:0]  byte_count,
	input  logic        last,
	// result side, queue style
	output logic        empty,
	input  logic        pop,
	output logic [63:0] hash_low,
	output logic [63:0] hash_high,
	output logic        too_long,
	// seed register write channel
	input  logic        seed_valid,
	output logic        seed_ready,
	input  logic [31:0] seed
);

	mm3_pkg::mm3_cmd_t     cmd;
	logic                  cmd_avail;
	logic                  cmd_pop;
	mm3_pkg::mm3_mul_req_t mul_req;
	mm3_pkg::mm3_mul_rsp_t mul_rsp;
	logic                  out_valid;
	logic                  out_pop;

	// the result register stands for a one-deep output queue
	assign empty   = !out_valid;
	assign out_pop = pop && out_valid;

	// front: takes each item, saturates the byte count, decides full mix or
	// tail, masks unused tail bytes and queues the command
	mm3_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.block_low  (block_low),
		.block_high (block_high),
		.byte_count (byte_count),
		.last       (last),
		.cmd_avail  (cmd_avail),
		.cmd_out    (cmd),
		.cmd_pop    (cmd_pop)
	);

	// shared 64x64 low-half multiplier, one 32x32 partial product a cycle while busy
	mm3_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	// back: lane premix, hash word recurrence, length fold, finalizer and
	// the result register; holds the seed and both running hash words
	mm3_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_avail  (cmd_avail),
		.cmd_in     (cmd),
		.cmd_pop    (cmd_pop),
		.seed_valid (seed_valid),
		.seed       (seed),
		.seed_ready (seed_ready),
		.mul_req    (mul_req),
		.mul_rsp    (mul_rsp),
		.out_pop    (out_pop),
		.out_valid  (out_valid),
		.hash_low   (hash_low),
		.hash_high  (hash_high),
		.too_long   (too_long)
	);

endmodule
